// File: rtl/rffu_pkg.sv
package rffu_pkg;

    // Frame size defaults.
    localparam int unsigned DEF_FRAME_WIDTH  = 240;
    localparam int unsigned DEF_FRAME_HEIGHT = 320;

    // Field widths of one request and one result.
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned COLOUR_W = 16;
    localparam int unsigned PIXEL_W  = 16;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned OUT_USER_W = 2;

    // Signed width that holds every mapped bound for frames up to 1024 pixels.
    localparam int unsigned COORD_W = 13;

    // Request kinds.
    localparam logic [ACTION_W-1:0] ACT_DRAW = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FILL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // Orientation codes.
    localparam logic [1:0] ORIENT_0   = 2'd0;
    localparam logic [1:0] ORIENT_90  = 2'd1;
    localparam logic [1:0] ORIENT_180 = 2'd2;
    localparam logic [1:0] ORIENT_270 = 2'd3;

    typedef struct packed {
        logic capture;
        logic map_en;
        logic clip_en;
        logic base_en;
        logic wr_en;
        logic rd_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic act_ok;
        logic is_read;
        logic oor;
        logic nonempty;
        logic fill_last;
        logic out_busy;
    } t_dp_sts;

    // The panel expects the two bytes of each colour word swapped.
    function automatic logic [PIXEL_W-1:0] swap_bytes(input logic [COLOUR_W-1:0] c);
        return {c[7:0], c[15:8]};
    endfunction

endpackage

// File: rtl/rotated_framebuffer_fill_unit.sv
// Rotated frame-store fill unit.
// Requests arrive as beats on the s_axis channel: tuser carries the action
// (draw pixel, fill rectangle, read pixel), tdata the logical corner, the
// rectangle size and the RGB565 colour. Each request yields exactly one
// result beat on m_axis: the stored word for an in-frame read (zero otherwise) in
// tdata, and the dirty and out-of-range flags in tuser.
// The orientation register is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while no request is in flight, which the unit does not enforce.
// A request is taken only when the unit is idle. It passes through the
// states MAP, CLIP and BASE; a read then reads its word in READ, and a draw
// or a fill writes its in-frame pixels in FILL, one word per cycle through
// the single write port of the frame store. A request that touches no word
// (no-op, empty fill, or one wholly outside the frame) goes from BASE
// straight to DONE, where each result is loaded. The next request can be
// taken in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, the unit
// finishes its current request and then holds until that register drains.
// Reset clears the dirty flag, the orientation (back to 0 degrees) and the
// output valid; the frame store is not cleared and reads of never-written
// words return whatever the memory holds.
module rotated_framebuffer_fill_unit
    import rffu_pkg::*;
#(
    parameter int unsigned FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int unsigned FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x[8:0], pos_y[17:9], size_x[26:18], size_y[35:27], colour[51:36], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [ACTION_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_value[15:0]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // dirty[0], out_of_range[1]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    ctrl_ready;
    logic    out_dirty;
    logic    out_oor;

    rffu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (ctrl_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rffu_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_action       (s_axis_tuser),
        .i_pos_x        (s_axis_tdata[8:0]),
        .i_pos_y        (s_axis_tdata[17:9]),
        .i_size_x       (s_axis_tdata[26:18]),
        .i_size_y       (s_axis_tdata[35:27]),
        .i_colour       (s_axis_tdata[51:36]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_pixel_value  (m_axis_tdata),
        .o_dirty        (out_dirty),
        .o_out_of_range (out_oor)
    );

    assign s_axis_tready = ctrl_ready;
    assign m_axis_tuser  = {out_oor, out_dirty};

endmodule

// File: rtl/rffu_datapath.sv
module rffu_datapath
    import rffu_pkg::*;
#(
    parameter int unsigned FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int unsigned FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_wr_data,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [POS_W-1:0]      i_size_x,
    input  logic [POS_W-1:0]      i_size_y,
    input  logic [COLOUR_W-1:0]   i_colour,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PIXEL_W-1:0]    o_pixel_value,
    output logic                  o_dirty,
    output logic                  o_out_of_range
);

    localparam int unsigned DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned COL_W  = $clog2(FRAME_WIDTH);
    localparam int unsigned ROW_W  = $clog2(FRAME_HEIGHT);
    localparam logic signed [COORD_W-1:0] W_S = COORD_W'(FRAME_WIDTH);
    localparam logic signed [COORD_W-1:0] H_S = COORD_W'(FRAME_HEIGHT);
    localparam logic signed [COORD_W-1:0] ONE_S = COORD_W'(1);

    logic [1:0]                r_orient;
    logic [ACTION_W-1:0]       r_action;
    logic [POS_W-1:0]          r_x, r_y, r_cx, r_cy;
    logic [PIXEL_W-1:0]        r_word;
    logic                      r_act_ok;
    logic signed [COORD_W-1:0] r_c0, r_c1, r_r0, r_r1;
    logic signed [COORD_W-1:0] n_c0, n_c1, n_r0, n_r1;
    logic signed [COORD_W-1:0] sx, sy, scx, scy;
    logic                      r_oor, n_oor;
    logic                      r_nonempty;
    logic signed [COORD_W-1:0] c0_clip, c1_clip, r0_clip, r1_clip;
    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          r_row;
    logic [ADDR_W-1:0]         r_base;
    logic [ADDR_W-1:0]         addr;
    logic                      row_end;
    logic                      r_dirty;
    logic [PIXEL_W-1:0]        r_rd_data;
    logic                      r_out_valid;
    logic [PIXEL_W-1:0]        r_pixel;
    logic                      r_out_dirty;
    logic                      r_out_oor;
    logic [PIXEL_W-1:0]        mem [DEPTH];

    assign sx  = COORD_W'(r_x);
    assign sy  = COORD_W'(r_y);
    assign scx = COORD_W'(r_cx);
    assign scy = COORD_W'(r_cy);

    always_comb begin
        unique case (r_orient)
            ORIENT_90: begin
                n_c0 = sy;
                n_c1 = sy + scy - ONE_S;
                n_r0 = H_S - sx - scx;
                n_r1 = H_S - ONE_S - sx;
            end
            ORIENT_180: begin
                n_c0 = W_S - sx - scx;
                n_c1 = W_S - ONE_S - sx;
                n_r0 = H_S - sy - scy;
                n_r1 = H_S - ONE_S - sy;
            end
            ORIENT_270: begin
                n_c0 = W_S - sy - scy;
                n_c1 = W_S - ONE_S - sy;
                n_r0 = sx;
                n_r1 = sx + scx - ONE_S;
            end
            default: begin
                n_c0 = sx;
                n_c1 = sx + scx - ONE_S;
                n_r0 = sy;
                n_r1 = sy + scy - ONE_S;
            end
        endcase
    end

    assign n_oor   = (r_c0 < 0) || (r_r0 < 0) || (r_c1 >= W_S) || (r_r1 >= H_S);
    assign c0_clip = (r_c0 < 0) ? '0 : r_c0;
    assign r0_clip = (r_r0 < 0) ? '0 : r_r0;
    assign c1_clip = (r_c1 > W_S - ONE_S) ? W_S - ONE_S : r_c1;
    assign r1_clip = (r_r1 > H_S - ONE_S) ? H_S - ONE_S : r_r1;

    assign addr    = r_base + ADDR_W'(r_col);
    assign row_end = (r_col == r_c1[COL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient    <= ORIENT_0;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_orient <= i_cfg_wr_data;
            end
            if (i_cmd.wr_en) begin
                r_dirty <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_word   <= swap_bytes(i_colour);
            if (i_action == ACT_FILL) begin
                r_cx     <= i_size_x;
                r_cy     <= i_size_y;
                r_act_ok <= (i_size_x != '0) && (i_size_y != '0);
            end else begin
                r_cx     <= POS_W'(1);
                r_cy     <= POS_W'(1);
                r_act_ok <= (i_action != ACT_NONE);
            end
        end
        if (i_cmd.map_en) begin
            r_c0 <= n_c0;
            r_c1 <= n_c1;
            r_r0 <= n_r0;
            r_r1 <= n_r1;
        end
        if (i_cmd.clip_en) begin
            r_oor      <= n_oor;
            r_nonempty <= (c0_clip <= c1_clip) && (r0_clip <= r1_clip);
            r_c0       <= c0_clip;
            r_c1       <= c1_clip;
            r_r0       <= r0_clip;
            r_r1       <= r1_clip;
        end
        if (i_cmd.base_en) begin
            r_base <= ADDR_W'(r_r0[ROW_W-1:0]) * ADDR_W'(FRAME_WIDTH);
            r_col  <= r_c0[COL_W-1:0];
            r_row  <= r_r0[ROW_W-1:0];
        end else if (i_cmd.wr_en) begin
            if (row_end) begin
                r_col  <= r_c0[COL_W-1:0];
                r_row  <= r_row + ROW_W'(1);
                r_base <= r_base + ADDR_W'(FRAME_WIDTH);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_pixel     <= (r_action == ACT_READ && r_act_ok && !r_oor) ? r_rd_data : '0;
            r_out_dirty <= r_dirty;
            r_out_oor   <= r_act_ok && r_oor;
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[addr] <= r_word;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[addr];
        end
    end

    assign o_sts.act_ok    = r_act_ok;
    assign o_sts.is_read   = (r_action == ACT_READ);
    assign o_sts.oor       = r_oor;
    assign o_sts.nonempty  = r_nonempty;
    assign o_sts.fill_last = row_end && (r_row == r_r1[ROW_W-1:0]);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_pixel;
    assign o_dirty        = r_out_dirty;
    assign o_out_of_range = r_out_oor;

`ifndef SYNTH
    a_wr_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (32'(addr) < DEPTH))
        else $error("frame store write beyond the frame");
    a_wr_only_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (r_nonempty && r_act_ok && r_action != ACT_READ))
        else $error("write issued for a request that writes nothing");
    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty |=> r_dirty)
        else $error("dirty flag cleared without reset");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

// File: rtl/rffu_ctrl.sv
module rffu_ctrl
    import rffu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        IDLE, MAP, CLIP, BASE, FILL, READ, DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = MAP;
                end
            end
            MAP: begin
                o_cmd.map_en = 1'b1;
                n_state      = CLIP;
            end
            CLIP: begin
                o_cmd.clip_en = 1'b1;
                n_state       = BASE;
            end
            BASE: begin
                o_cmd.base_en = 1'b1;
                if (!i_sts.act_ok) begin
                    n_state = DONE;
                end else if (i_sts.is_read) begin
                    n_state = i_sts.oor ? DONE : READ;
                end else begin
                    n_state = i_sts.nonempty ? FILL : DONE;
                end
            end
            FILL: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = DONE;
                end
            end
            READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = DONE;
            end
            DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = IDLE;
                end
            end
            default: n_state = IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == IDLE);

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded over an untaken result");
    a_rd_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> (r_state == DONE))
        else $error("read data not handed to the result stage");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_en || o_cmd.rd_en) |-> !o_in_ready)
        else $error("input ready while the frame store is in use");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rffu_pkg::*;

    localparam int FW = int'(DEF_FRAME_WIDTH);
    localparam int FH = int'(DEF_FRAME_HEIGHT);
    localparam int RX_HOLD_CYCLES = 400;
    localparam longint RUN_LIMIT_NS = 64'd30_000_000;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               dirty;
        logic               oor;
    } t_px_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [1:0]            i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // pos_x[8:0], pos_y[17:9], size_x[26:18], size_y[35:27], colour[51:36], zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // action[1:0]
    logic [ACTION_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // pixel_value[15:0]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // dirty[0], out_of_range[1]
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // Shadow of the frame store, the dirty flag and the orientation register.
    logic [PIXEL_W-1:0] frame_words [0:FW*FH-1];
    logic               dirty_seen;
    logic [1:0]         orient_now;

    t_px_result pending_results [$];

    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold_req;
    int big_fills_left;

    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_fills;
    int unsigned n_reads;
    int unsigned n_oor;
    int unsigned n_orient_writes;
    int unsigned n_errors;

    rotated_framebuffer_fill_unit #(
        .FRAME_WIDTH  (DEF_FRAME_WIDTH),
        .FRAME_HEIGHT (DEF_FRAME_HEIGHT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Maps the request through the current orientation, clips it to the frame
    // and applies it to the shadow store.
    function automatic t_px_result paint_request(input logic [1:0] act, input int x,
                                                 input int y, input int cx, input int cy,
                                                 input logic [COLOUR_W-1:0] colour);
        t_px_result res;
        int c0, c1, r0, r1;
        res = '0;
        if (act == ACT_DRAW || act == ACT_READ) begin
            cx = 1;
            cy = 1;
        end
        if (act != ACT_NONE && cx > 0 && cy > 0) begin
            case (orient_now)
                ORIENT_90: begin
                    c0 = y;           c1 = y + cy - 1;
                    r0 = FH - x - cx; r1 = FH - 1 - x;
                end
                ORIENT_180: begin
                    c0 = FW - x - cx; c1 = FW - 1 - x;
                    r0 = FH - y - cy; r1 = FH - 1 - y;
                end
                ORIENT_270: begin
                    c0 = FW - y - cy; c1 = FW - 1 - y;
                    r0 = x;           r1 = x + cx - 1;
                end
                default: begin
                    c0 = x; c1 = x + cx - 1;
                    r0 = y; r1 = y + cy - 1;
                end
            endcase
            if (c0 < 0 || r0 < 0 || c1 >= FW || r1 >= FH)
                res.oor = 1'b1;
            if (c0 < 0) c0 = 0;
            if (r0 < 0) r0 = 0;
            if (c1 > FW - 1) c1 = FW - 1;
            if (r1 > FH - 1) r1 = FH - 1;
            if (act == ACT_READ) begin
                if (!res.oor)
                    res.pixel = frame_words[r0 * FW + c0];
            end else if (c0 <= c1 && r0 <= r1) begin
                for (int r = r0; r <= r1; r++)
                    for (int c = c0; c <= c1; c++)
                        frame_words[r * FW + c] = {colour[7:0], colour[15:8]};
                dirty_seen = 1'b1;
            end
        end
        res.dirty = dirty_seen;
        return res;
    endfunction

    // Offers one request and returns after the beat that carries it is taken.
    task automatic send_req(input logic [1:0] act, input logic [8:0] x, input logic [8:0] y,
                            input logic [8:0] cx, input logic [8:0] cy,
                            input logic [COLOUR_W-1:0] colour);
        t_px_result res;
        s_axis_tdata  <= {4'b0, colour, cy, cx, y, x};
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        res = paint_request(act, int'(x), int'(y), int'(cx), int'(cy), colour);
        pending_results.push_back(res);
        n_items++;
        if (act == ACT_FILL) n_fills++;
        if (act == ACT_READ) n_reads++;
        if (res.oor) n_oor++;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_orientation(input logic [1:0] orient);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= orient;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        orient_now = orient;
        n_orient_writes++;
    endtask

    // Mostly write-then-read-back pairs, plus lone requests and noise.
    task automatic random_burst(input int n_req);
        int sent, pick, x, y, cx, cy;
        sent = 0;
        while (sent < n_req) begin
            pick = $urandom_range(0, 99);
            x = $urandom_range(0, 319);
            y = $urandom_range(0, 319);
            if (pick < 10) begin
                send_req(2'($urandom), 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                         9'($urandom_range(0, 15)), 9'($urandom_range(0, 15)), 16'($urandom));
                sent += 1;
            end else if (pick < 45) begin
                send_req(ACT_DRAW, 9'(x), 9'(y), 9'($urandom), 9'($urandom), 16'($urandom));
                send_req(ACT_READ, 9'(x), 9'(y), 9'($urandom), 9'($urandom), 16'($urandom));
                sent += 2;
            end else if (pick < 75) begin
                // Only a handful of fills cover large areas, as each writes every pixel it covers.
                if (big_fills_left > 0 && $urandom_range(0, 59) == 0) begin
                    big_fills_left--;
                    cx = $urandom_range(1, 320);
                    cy = $urandom_range(1, 320);
                end else begin
                    cx = $urandom_range(1, 8);
                    cy = $urandom_range(1, 8);
                end
                send_req(ACT_FILL, 9'(x), 9'(y), 9'(cx), 9'(cy), 16'($urandom));
                send_req(ACT_READ, 9'(x + $urandom_range(0, cx - 1)),
                         9'(y + $urandom_range(0, cy - 1)),
                         9'($urandom), 9'($urandom), 16'($urandom));
                sent += 2;
            end else if (pick < 88) begin
                send_req(ACT_READ, 9'(x), 9'(y), 9'($urandom), 9'($urandom), 16'($urandom));
                sent += 1;
            end else begin
                send_req(ACT_DRAW, 9'(x), 9'(y), 9'($urandom), 9'($urandom), 16'($urandom));
                sent += 1;
            end
        end
    endtask

    // Nothing here writes the store, so the dirty flag must stay clear.
    task automatic test_reset_state();
        send_req(ACT_NONE, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 16'hffff);
        send_req(ACT_FILL, 0, 0, 0, 5, 16'h1111);
        send_req(ACT_FILL, 0, 0, 5, 0, 16'h2222);
        send_req(ACT_DRAW, 240, 0, 1, 1, 16'h3333);
        send_req(ACT_READ, 9'h1ff, 9'h1ff, 0, 0, 16'h0000);
    endtask

    // The whole frame is written first, so later reads never hit an unwritten word.
    task automatic test_frame_fill();
        send_req(ACT_FILL, 0, 0, 240, 320, 16'h1234);
        send_req(ACT_READ, 0, 0, 0, 0, 16'h0000);
        send_req(ACT_DRAW, 239, 319, 0, 0, 16'hffff);
        send_req(ACT_READ, 239, 319, 0, 0, 16'h0000);
        send_req(ACT_FILL, 200, 300, 9'h1ff, 1, 16'h00ff);
        send_req(ACT_READ, 239, 300, 0, 0, 16'h0000);
    endtask

    task automatic test_orientations();
        set_orientation(ORIENT_90);
        send_req(ACT_FILL, 0, 0, 320, 320, 16'ha55a);
        send_req(ACT_DRAW, 319, 239, 0, 0, 16'h8001);
        send_req(ACT_READ, 319, 239, 0, 0, 16'h0000);
        send_req(ACT_READ, 0, 240, 0, 0, 16'h0000);
        set_orientation(ORIENT_180);
        send_req(ACT_DRAW, 0, 0, 0, 0, 16'h0000);
        send_req(ACT_READ, 0, 0, 0, 0, 16'h0000);
        send_req(ACT_READ, 239, 319, 0, 0, 16'h0000);
        send_req(ACT_DRAW, 240, 0, 0, 0, 16'h5a5a);
        set_orientation(ORIENT_270);
        send_req(ACT_DRAW, 0, 0, 0, 0, 16'hfedc);
        send_req(ACT_READ, 0, 0, 0, 0, 16'h0000);
        send_req(ACT_FILL, 300, 230, 30, 20, 16'h0f0f);
        send_req(ACT_READ, 319, 239, 0, 0, 16'h0000);
        send_req(ACT_NONE, 0, 0, 0, 0, 16'h0000);
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 8; phase++) begin
            set_orientation(phase < 4 ? 2'(phase) : 2'($urandom));
            random_burst(160);
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming.
    task automatic test_output_hold();
        set_orientation(ORIENT_0);
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        random_burst(50);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_back_to_back();
        set_orientation(ORIENT_270);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_burst(520);
    endtask

    // Receiver side: random stalls, plus one long hold on request.
    initial begin : rx_side
        m_axis_tready <= 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_px_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, pixel %h flags %b",
                         $time, m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.pixel) begin
                    $display("%0t: pixel_value expected %h actual %h",
                             $time, want.pixel, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tuser[0] !== want.dirty) begin
                    $display("%0t: dirty expected %b actual %b",
                             $time, want.dirty, m_axis_tuser[0]);
                    n_errors++;
                end
                if (m_axis_tuser[1] !== want.oor) begin
                    $display("%0t: out_of_range expected %b actual %b",
                             $time, want.oor, m_axis_tuser[1]);
                    n_errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached with %0d results outstanding",
                 $time, pending_results.size());
        $display("rotated_framebuffer_fill_unit: mismatch");
        $finish;
    end

    initial begin : main_seq
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= ORIENT_0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        s_axis_tuser    <= ACT_NONE;
        dirty_seen      = 1'b0;
        orient_now      = ORIENT_0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        rx_hold_req     = 1'b0;
        big_fills_left  = 6;
        n_items         = 0;
        n_results       = 0;
        n_fills         = 0;
        n_reads         = 0;
        n_oor           = 0;
        n_orient_writes = 0;
        n_errors        = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_frame_fill();
        test_orientations();
        test_random_mix();
        test_output_hold();
        test_back_to_back();

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests (%0d fills, %0d reads), checked %0d result beats.",
                 n_items, n_fills, n_reads, n_results);
        $display("%0d requests clipped at the frame edge, %0d orientation writes, %0d errors.",
                 n_oor, n_orient_writes, n_errors);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("rotated_framebuffer_fill_unit: match");
        end else begin
            $display("rotated_framebuffer_fill_unit: mismatch");
        end
        $finish;
    end

endmodule
